>>> rtl/ths_pkg.sv
// shared constants and types for the timer heap scheduler
package ths_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int MAX_FIRES  = 63;
  localparam int SLOT_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int ID_W       = 6;
  localparam int NUM_TIMERS = 64;
  localparam int TIME_W     = 48;
  localparam int PER_W      = 32;
  localparam int FIRE_W     = 6;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_UPDATE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [2:0] KIND_ACK        = 3'd0;
  localparam logic [2:0] KIND_FIRED      = 3'd1;
  localparam logic [2:0] KIND_TICK_DONE  = 3'd2;
  localparam logic [2:0] KIND_FULL       = 3'd3;
  localparam logic [2:0] KIND_ACTIVE     = 3'd4;
  localparam logic [2:0] KIND_NOT_ACTIVE = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD1,
    ST_DN_RD2,
    ST_DN_CMP,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_TICK_LAST,
    ST_TICK_LAST2,
    ST_DONE
  } state_t;

endpackage

>>> rtl/timer_heap_scheduler.sv
// timer heap scheduler top level: heap memories and sift sequencer
// errors need no sift; an insert sifts up, an update sifts up or else down,
//   and a tick fires due timers one at a time, each followed by a sift-down
// one command at a time: busy stays high until the last result strobe
// the heap memories have one read port each, so both children are read in turn
// reset clears heap count, active flags and the sequencer; memories are not cleared
// results cannot be stalled: each is shown for one cycle with out_valid
module timer_heap_scheduler
  import ths_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [TIME_W-1:0] time_value,
  input  logic [PER_W-1:0]  period,
  output logic              out_valid,
  output logic [2:0]        kind,
  output logic [ID_W-1:0]   fired_id,
  output logic [TIME_W-1:0] due_time,
  output logic              repeats,
  output logic              more_pending,
  output logic              last
);

  // heap memories and per-timer memories
  logic [ID_W-1:0]   heap_ids_mem [HEAP_DEPTH];
  logic [TIME_W-1:0] heap_due_mem [HEAP_DEPTH];
  logic [SLOT_W-1:0] slot_mem     [NUM_TIMERS];
  logic [PER_W-1:0]  per_mem      [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] active;
  logic [CNT_W-1:0]  count;

  state_t state, state_next;

  // latched command
  logic [1:0]        c_cmd;
  logic [ID_W-1:0]   c_id;
  logic [TIME_W-1:0] c_tv;
  logic [PER_W-1:0]  c_per;

  // element being sifted
  logic [ID_W-1:0]   s_id;
  logic [TIME_W-1:0] s_due;
  logic [SLOT_W-1:0] s_pos;
  logic              moved;
  logic              from_update;
  logic [FIRE_W-1:0] nfired;
  logic              is_tick;

  // fired entry info
  logic [ID_W-1:0]   f_id;
  logic [TIME_W-1:0] f_due;
  logic              f_rep;

  // heap read port
  logic [SLOT_W-1:0] h_raddr;
  logic              h_re;
  logic [ID_W-1:0]   h_rid;
  logic [TIME_W-1:0] h_rdue;
  // heap write port
  logic              h_we;
  logic [SLOT_W-1:0] h_waddr;
  logic [ID_W-1:0]   h_wid;
  logic [TIME_W-1:0] h_wdue;
  // slot/period memory reads
  logic [SLOT_W-1:0] slot_rd;
  logic [PER_W-1:0]  per_rd;
  logic [ID_W-1:0]   tm_raddr;

  // first child kept while the second is read
  logic [ID_W-1:0]   c1_id;
  logic [TIME_W-1:0] c1_due;
  logic              c1_ok;

  always_ff @(posedge clk) begin
    if (h_re) begin
      h_rid  <= heap_ids_mem[h_raddr];
      h_rdue <= heap_due_mem[h_raddr];
    end
    if (h_we) begin
      heap_ids_mem[h_waddr] <= h_wid;
      heap_due_mem[h_waddr] <= h_wdue;
      slot_mem[h_wid] <= h_waddr;
    end
  end

  always_ff @(posedge clk) begin
    slot_rd <= slot_mem[tm_raddr];
    per_rd  <= per_mem[tm_raddr];
    if (state == ST_DECODE && c_cmd == CMD_INSERT && !active[c_id] &&
        count < CNT_W'(HEAP_DEPTH))
      per_mem[c_id] <= c_per;
  end

  // combinational helpers
  logic [SLOT_W-1:0] parent_pos;
  logic [CNT_W:0]    ch1, ch2;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] rearm;
  assign parent_pos = (s_pos - SLOT_W'(1)) >> 1;
  assign ch1 = {1'b0, s_pos, 1'b1};
  assign ch2 = ch1 + (CNT_W+1)'(1);
  assign sum = {1'b0, h_rdue} + (TIME_W+1)'(per_rd);
  assign rearm = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  // sequencer registers
  logic [ID_W-1:0]   s_id_next;
  logic [TIME_W-1:0] s_due_next;
  logic [SLOT_W-1:0] s_pos_next;
  logic              moved_next, from_update_next;
  logic [CNT_W-1:0]  count_next;
  logic [NUM_TIMERS-1:0] active_next;
  logic [FIRE_W-1:0] nfired_next;
  logic [ID_W-1:0]   c1_id_next;
  logic [TIME_W-1:0] c1_due_next;
  logic              c1_ok_next;
  logic [ID_W-1:0]   f_id_next;
  logic [TIME_W-1:0] f_due_next;
  logic              f_rep_next;
  logic              ov, ov_next;
  logic [2:0]        ok_kind, ok_kind_next;
  logic              o_more, o_more_next, o_last, o_last_next;
  logic [ID_W-1:0]   o_id, o_id_next;
  logic [TIME_W-1:0] o_due, o_due_next;
  logic              o_rep, o_rep_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      active <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      active <= active_next;
      ov <= ov_next;
    end
    if (start && !busy) begin
      c_cmd <= cmd; c_id <= timer_id; c_tv <= time_value; c_per <= period;
    end
    s_id <= s_id_next; s_due <= s_due_next; s_pos <= s_pos_next;
    moved <= moved_next; from_update <= from_update_next;
    nfired <= nfired_next;
    c1_id <= c1_id_next; c1_due <= c1_due_next; c1_ok <= c1_ok_next;
    f_id <= f_id_next; f_due <= f_due_next; f_rep <= f_rep_next;
    ok_kind <= ok_kind_next; o_more <= o_more_next; o_last <= o_last_next;
    o_id <= o_id_next; o_due <= o_due_next; o_rep <= o_rep_next;
  end

  assign busy = (state != ST_IDLE);
  assign is_tick = (c_cmd == CMD_TICK);
  assign out_valid = ov;
  assign kind = ok_kind;
  assign fired_id = o_id;
  assign due_time = o_due;
  assign repeats = o_rep;
  assign more_pending = o_more;
  assign last = o_last;

  always_comb begin
    state_next = state;
    s_id_next = s_id; s_due_next = s_due; s_pos_next = s_pos;
    moved_next = moved; from_update_next = from_update;
    count_next = count; active_next = active; nfired_next = nfired;
    c1_id_next = c1_id; c1_due_next = c1_due; c1_ok_next = c1_ok;
    f_id_next = f_id; f_due_next = f_due; f_rep_next = f_rep;
    ov_next = 1'b0;
    ok_kind_next = ok_kind; o_more_next = 1'b0; o_last_next = 1'b0;
    o_id_next = o_id; o_due_next = o_due; o_rep_next = 1'b0;
    h_re = 1'b0; h_raddr = '0;
    h_we = 1'b0; h_waddr = s_pos; h_wid = s_id; h_wdue = s_due;
    tm_raddr = c_id;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        // slot and period of c_id are readable next cycle
        o_id_next = c_id; o_due_next = c_tv; o_last_next = 1'b1;
        nfired_next = '0;
        case (c_cmd)
          CMD_INSERT: begin
            if (active[c_id]) begin
              ov_next = 1'b1; ok_kind_next = KIND_ACTIVE; state_next = ST_DONE;
            end else if (count >= CNT_W'(HEAP_DEPTH)) begin
              ov_next = 1'b1; ok_kind_next = KIND_FULL; state_next = ST_DONE;
            end else begin
              active_next[c_id] = 1'b1;
              count_next = count + CNT_W'(1);
              s_id_next = c_id; s_due_next = c_tv;
              s_pos_next = count[SLOT_W-1:0];
              moved_next = 1'b0; from_update_next = 1'b0;
              state_next = ST_UP_RD;
            end
          end
          CMD_UPDATE: begin
            if (!active[c_id]) begin
              ov_next = 1'b1; ok_kind_next = KIND_NOT_ACTIVE; state_next = ST_DONE;
            end else begin
              s_id_next = c_id; s_due_next = c_tv;
              moved_next = 1'b0; from_update_next = 1'b1;
              s_pos_next = '1; // marker: slot to be loaded
              state_next = ST_UP_RD;
            end
          end
          CMD_TICK: begin
            state_next = ST_TICK_RD;
          end
          default: begin
            ov_next = 1'b1; ok_kind_next = KIND_ACK; state_next = ST_DONE;
          end
        endcase
        o_last_next = 1'b1;
        if (state_next != ST_DONE) o_last_next = 1'b0;
      end
      ST_UP_RD: begin
        // on update, take the slot from the slot memory the first time
        if (from_update && !moved && s_pos == '1 && s_id == c_id) begin
          s_pos_next = (CNT_W'(slot_rd) >= count) ? '0 : slot_rd;
          moved_next = 1'b1; // temporarily marks slot loaded
          state_next = ST_UP_RD;
        end else if (s_pos == '0) begin
          h_we = 1'b1;
          state_next = (from_update && !(moved && s_pos != '0) &&
                        !f_rep) ? ST_DN_RD1 : ST_DONE;
          if (from_update) begin
            // decided below in ST_UP_CMP path; here root reached
            state_next = f_rep ? ST_DONE : ST_DN_RD1;
            h_we = f_rep;
          end else begin
            ov_next = 1'b1; ok_kind_next = KIND_ACK; o_last_next = 1'b1;
            o_id_next = c_id; o_due_next = c_tv;
          end
        end else begin
          h_re = 1'b1; h_raddr = parent_pos;
          state_next = ST_UP_CMP;
        end
        if (from_update && state == ST_UP_RD && s_pos == '1 && s_id == c_id && !moved)
          f_rep_next = 1'b0; // f_rep tracks whether the update moved up
        if (state_next == ST_DONE && from_update) begin
          ov_next = 1'b1; ok_kind_next = KIND_ACK; o_last_next = 1'b1;
          o_id_next = c_id; o_due_next = c_tv;
        end
      end
      ST_UP_CMP: begin
        if (h_rdue > s_due) begin
          h_we = 1'b1; h_wid = h_rid; h_wdue = h_rdue;
          s_pos_next = parent_pos;
          if (from_update) f_rep_next = 1'b1;
          state_next = ST_UP_RD;
        end else if (from_update && !f_rep) begin
          state_next = ST_DN_RD1;
        end else begin
          h_we = 1'b1;
          ov_next = 1'b1; ok_kind_next = KIND_ACK; o_last_next = 1'b1;
          o_id_next = c_id; o_due_next = c_tv;
          state_next = ST_DONE;
        end
      end
      ST_DN_RD1: begin
        c1_ok_next = (ch1 < (CNT_W+1)'(count));
        if (ch1 < (CNT_W+1)'(count)) begin
          h_re = 1'b1; h_raddr = ch1[SLOT_W-1:0];
          state_next = ST_DN_RD2;
        end else begin
          h_we = 1'b1;
          state_next = is_tick ? ST_TICK_RD : ST_DONE;
          if (!is_tick) begin
            ov_next = 1'b1; ok_kind_next = KIND_ACK; o_last_next = 1'b1;
            o_id_next = c_id; o_due_next = c_tv;
          end
        end
      end
      ST_DN_RD2: begin
        c1_id_next = h_rid; c1_due_next = h_rdue;
        if (ch2 < (CNT_W+1)'(count)) begin
          h_re = 1'b1; h_raddr = ch2[SLOT_W-1:0];
          state_next = ST_DN_CMP;
        end else begin
          c1_ok_next = 1'b0; // reuse: only one child
          state_next = ST_DN_CMP;
        end
      end
      ST_DN_CMP: begin
        // c1_ok low here means no second child
        if (s_due > c1_due && (!c1_ok || c1_due <= h_rdue)) begin
          h_we = 1'b1; h_wid = c1_id; h_wdue = c1_due;
          s_pos_next = ch1[SLOT_W-1:0];
          state_next = ST_DN_RD1;
        end else if (c1_ok && s_due > h_rdue && c1_due > h_rdue) begin
          h_we = 1'b1; h_wid = h_rid; h_wdue = h_rdue;
          s_pos_next = ch2[SLOT_W-1:0];
          state_next = ST_DN_RD1;
        end else begin
          h_we = 1'b1;
          state_next = is_tick ? ST_TICK_RD : ST_DONE;
          if (!is_tick) begin
            ov_next = 1'b1; ok_kind_next = KIND_ACK; o_last_next = 1'b1;
            o_id_next = c_id; o_due_next = c_tv;
          end
        end
      end
      ST_TICK_RD: begin
        h_re = 1'b1; h_raddr = '0;
        state_next = ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        // root in h_rid/h_rdue; its period read from per_rd next
        tm_raddr = h_rid;
        if (count != '0 && h_rdue < c_tv && nfired != FIRE_W'(MAX_FIRES)) begin
          f_id_next = h_rid; f_due_next = h_rdue;
          state_next = ST_TICK_LAST;
          h_re = 1'b1; h_raddr = '0; // keep root on read port
        end else begin
          ov_next = 1'b1; ok_kind_next = KIND_TICK_DONE; o_last_next = 1'b1;
          o_id_next = '0; o_due_next = '0;
          o_more_next = (count != '0 && h_rdue < c_tv);
          state_next = ST_DONE;
        end
      end
      ST_TICK_LAST: begin
        // per_rd is the fired timer's period, h_rdue still the root due
        ov_next = 1'b1; ok_kind_next = KIND_FIRED;
        o_id_next = f_id; o_due_next = f_due;
        nfired_next = nfired + FIRE_W'(1);
        s_pos_next = '0;
        if (per_rd != '0) begin
          o_rep_next = 1'b1;
          s_id_next = f_id; s_due_next = rearm;
          state_next = ST_DN_RD1;
        end else begin
          active_next[f_id] = 1'b0;
          count_next = count - CNT_W'(1);
          h_re = 1'b1; h_raddr = SLOT_W'(count - CNT_W'(1));
          state_next = ST_TICK_LAST2;
        end
      end
      ST_TICK_LAST2: begin
        s_id_next = h_rid; s_due_next = h_rdue;
        state_next = (count != '0) ? ST_DN_RD1 : ST_TICK_RD;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(HEAP_DEPTH)) else $error("heap count above depth");
  a_active_pop: assert property (@(posedge clk) disable iff (rst)
    $countones(active) == int'(count)) else $error("active flags and count differ");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> !out_valid) else $error("result outside a command");
  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    nfired <= FIRE_W'(MAX_FIRES)) else $error("too many firings in one tick");
`endif

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the timer heap scheduler
module tb_top;
  import ths_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = CMD_INSERT;
  logic [ID_W-1:0]   timer_id = '0;
  logic [TIME_W-1:0] time_value = '0;
  logic [PER_W-1:0]  period = '0;
  logic              out_valid;
  logic [2:0]        kind;
  logic [ID_W-1:0]   fired_id;
  logic [TIME_W-1:0] due_time;
  logic              repeats;
  logic              more_pending;
  logic              last;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] due;
    logic              rep;
    logic              more;
    logic              lst;
  } sched_result_t;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  timer_heap_scheduler i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .timer_id(timer_id), .time_value(time_value), .period(period),
    .out_valid(out_valid), .kind(kind), .fired_id(fired_id),
    .due_time(due_time), .repeats(repeats), .more_pending(more_pending),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // own copy of the heap and timer table
  logic [ID_W-1:0]   hp_id  [HEAP_DEPTH];
  logic [TIME_W-1:0] hp_due [HEAP_DEPTH];
  int unsigned       slot_of [NUM_TIMERS];
  logic [PER_W-1:0]  per_of  [NUM_TIMERS];
  bit                armed   [NUM_TIMERS];
  int unsigned       hcount;

  sched_result_t expected_results[$];
  int errors = 0;
  bit idle_on = 1'b1;

  function automatic void put(int unsigned s, logic [ID_W-1:0] id, logic [TIME_W-1:0] d);
    hp_id[s] = id;
    hp_due[s] = d;
    slot_of[id] = s;
  endfunction

  function automatic bit heap_up(int unsigned s, logic [ID_W-1:0] id, logic [TIME_W-1:0] d);
    int unsigned p;
    bit moved;
    moved = 1'b0;
    while (s > 0) begin
      p = (s - 1) >> 1;
      if (hp_due[p] > d) begin
        put(s, hp_id[p], hp_due[p]);
        s = p;
        moved = 1'b1;
      end else break;
    end
    put(s, id, d);
    return moved;
  endfunction

  function automatic void heap_down(int unsigned s, logic [ID_W-1:0] id,
                                    logic [TIME_W-1:0] d);
    int unsigned m, c1, c2;
    logic [TIME_W-1:0] md;
    forever begin
      m = s;
      md = d;
      c1 = 2 * s + 1;
      c2 = 2 * s + 2;
      if (c1 < hcount && md > hp_due[c1]) begin
        m = c1;
        md = hp_due[c1];
      end
      if (c2 < hcount && md > hp_due[c2]) m = c2;
      if (m == s) break;
      put(s, hp_id[m], hp_due[m]);
      s = m;
    end
    put(s, id, d);
  endfunction

  function automatic void push_result(logic [2:0] k, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] d, logic rp, logic mp, logic ls);
    sched_result_t r;
    r = '{kind: k, id: id, due: d, rep: rp, more: mp, lst: ls};
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_command(logic [1:0] c, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] tv, logic [PER_W-1:0] per);
    int n;
    int unsigned s;
    logic [ID_W-1:0] fid;
    logic [TIME_W-1:0] d;
    logic [TIME_W:0] nd;
    case (c)
      CMD_INSERT: begin
        if (armed[id]) push_result(KIND_ACTIVE, id, tv, 1'b0, 1'b0, 1'b1);
        else if (hcount >= HEAP_DEPTH) push_result(KIND_FULL, id, tv, 1'b0, 1'b0, 1'b1);
        else begin
          per_of[id] = per;
          armed[id] = 1'b1;
          hcount++;
          void'(heap_up(hcount - 1, id, tv));
          push_result(KIND_ACK, id, tv, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_UPDATE: begin
        if (!armed[id]) push_result(KIND_NOT_ACTIVE, id, tv, 1'b0, 1'b0, 1'b1);
        else begin
          s = slot_of[id];
          if (s >= hcount) s = 0;
          if (!heap_up(s, id, tv)) heap_down(slot_of[id], id, tv);
          push_result(KIND_ACK, id, tv, 1'b0, 1'b0, 1'b1);
        end
      end
      CMD_TICK: begin
        n = 0;
        while (hcount > 0 && hp_due[0] < tv && n < MAX_FIRES) begin
          fid = hp_id[0];
          d = hp_due[0];
          if (per_of[fid] != 0) begin
            nd = {1'b0, d} + (TIME_W+1)'(per_of[fid]);
            heap_down(0, fid, nd[TIME_W] ? TIME_MAX : nd[TIME_W-1:0]);
            push_result(KIND_FIRED, fid, d, 1'b1, 1'b0, 1'b0);
          end else begin
            armed[fid] = 1'b0;
            hcount--;
            if (hcount > 0) heap_down(0, hp_id[hcount], hp_due[hcount]);
            push_result(KIND_FIRED, fid, d, 1'b0, 1'b0, 1'b0);
          end
          n++;
        end
        push_result(KIND_TICK_DONE, '0, '0, 1'b0, (hcount > 0 && hp_due[0] < tv), 1'b1);
      end
      default: push_result(KIND_ACK, id, tv, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // one transaction: drive on falling edge, accepted on rising edge with busy low
  task automatic send_command(logic [1:0] c, logic [ID_W-1:0] id,
      logic [TIME_W-1:0] tv, logic [PER_W-1:0] per);
    while (idle_on && $urandom_range(99) < 15) @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    timer_id <= id;
    time_value <= tv;
    period <= per;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_command(c, id, tv, per);
    @(negedge clk);
    start <= 1'b0;
    // wait for the block to finish before the next command
    while (expected_results.size() != 0 || busy) @(negedge clk);
  endtask

  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", kind, fired_id);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, kind); errors++;
        end
        if (fired_id !== e.id) begin
          $error("fired_id: expected %0d actual %0d", e.id, fired_id); errors++;
        end
        if (due_time !== e.due) begin
          $error("due_time: expected %0h actual %0h", e.due, due_time); errors++;
        end
        if (repeats !== e.rep) begin
          $error("repeats: expected %0d actual %0d", e.rep, repeats); errors++;
        end
        if (more_pending !== e.more) begin
          $error("more_pending: expected %0d actual %0d", e.more, more_pending);
          errors++;
        end
        if (last !== e.lst) begin
          $error("last: expected %0d actual %0d", e.lst, last); errors++;
        end
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic test_errors_and_extremes();
    send_command(CMD_UPDATE, 6'd5, 48'd100, 32'd0);
    send_command(CMD_INSERT, 6'd0, 48'd0, 32'd0);
    send_command(CMD_INSERT, 6'd0, 48'd9, 32'd1);
    send_command(CMD_INSERT, 6'd63, TIME_MAX, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 6'd7, TIME_MAX - 48'd5, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 6'd9, 48'd50, 32'd10);
    send_command(CMD_UPDATE, 6'd9, 48'd1, 32'd0);
    send_command(CMD_UPDATE, 6'd0, 48'd500, 32'd0);
    send_command(2'd3, 6'd42, rand_time(), 32'hDEAD_BEEF);
    send_command(CMD_TICK, 6'd0, 48'd0, 32'd0);
    send_command(CMD_TICK, 6'd0, 48'd600, 32'd0);
    // periodic saturation near the top of the time range
    send_command(CMD_TICK, 6'd0, TIME_MAX, 32'd0);
    send_command(CMD_TICK, 6'd0, TIME_MAX, 32'd0);
  endtask

  task automatic test_full_heap();
    for (int i = 0; i < NUM_TIMERS; i++)
      send_command(CMD_INSERT, i[ID_W-1:0], TIME_W'($urandom_range(200)),
                   $urandom_range(1));
    send_command(CMD_INSERT, 6'd3, 48'd5, 32'd0);
    // more than the firing limit expire at once
    send_command(CMD_TICK, 6'd0, 48'd1000, 32'd0);
    send_command(CMD_TICK, 6'd0, 48'd1000, 32'd0);
    send_command(CMD_TICK, 6'd0, TIME_MAX, 32'd0);
    for (int i = 0; i < 12; i++) send_command(CMD_TICK, 6'd0, TIME_MAX, 32'd0);
  endtask

  task automatic test_random(int count);
    int r;
    logic [TIME_W-1:0] now;
    now = 48'd1000;
    for (int i = 0; i < count; i++) begin
      idle_on = !(i >= count / 3 && i < count / 2);
      r = $urandom_range(99);
      now = now + TIME_W'($urandom_range(40));
      if (r < 40)
        send_command(CMD_INSERT, ID_W'($urandom), now + TIME_W'($urandom_range(100)),
                     ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(60));
      else if (r < 62)
        send_command(CMD_UPDATE, ID_W'($urandom), now + TIME_W'($urandom_range(100)),
                     $urandom);
      else if (r < 92)
        send_command(CMD_TICK, ID_W'($urandom), now, $urandom);
      else if (r < 96)
        send_command(2'($urandom_range(3)), ID_W'($urandom), rand_time(), $urandom);
      else
        send_command(2'd3, ID_W'($urandom), rand_time(), $urandom);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;
    hcount = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_errors_and_extremes();
    test_full_heap();
    test_random(28);
    repeat (50) @(negedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/ths_pkg.sv
rtl/timer_heap_scheduler.sv
verif/tb_top.sv
